[rtl/sxt_pkg.sv]
// shared types, constants and codes for the s-expression tokenizer
// no dependencies; imported by every module of the block
`default_nettype none
package sxt_pkg;

    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 12;
    localparam int LENGTH_BITS = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QLVL_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] KIND_OPAREN = 3'd0;
    localparam logic [2:0] KIND_CPAREN = 3'd1;
    localparam logic [2:0] KIND_QUOTE  = 3'd2;
    localparam logic [2:0] KIND_STRING = 3'd3;
    localparam logic [2:0] KIND_SYMBOL = 3'd4;
    localparam logic [2:0] KIND_ATOM   = 3'd5;
    localparam logic [2:0] KIND_END    = 3'd6;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_STRING_END   = 3'd1;
    localparam logic [2:0] ERR_LINE_END     = 3'd2;
    localparam logic [2:0] ERR_SYMBOL_END   = 3'd3;
    localparam logic [2:0] ERR_SYMBOL_SPACE = 3'd4;
    localparam logic [2:0] ERR_SYMBOL_PAREN = 3'd5;

    localparam logic [7:0] CH_END     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_VTAB    = 8'h0B;
    localparam logic [7:0] CH_FFEED   = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_OPAREN  = 8'h28;
    localparam logic [7:0] CH_CPAREN  = 8'h29;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;

    typedef enum logic [4:0] {
        M_IDLE    = 5'b00001,
        M_STRING  = 5'b00010,
        M_SYMBOL  = 5'b00100,
        M_ATOM    = 5'b01000,
        M_COMMENT = 5'b10000
    } t_mode;

    typedef struct packed {
        t_mode                  mode;
        logic [LINE_BITS-1:0]   cur_line;
        logic [COLUMN_BITS-1:0] cur_col;
        logic [LINE_BITS-1:0]   tok_line;
        logic [COLUMN_BITS-1:0] tok_col;
        logic [LENGTH_BITS-1:0] run_len;
    } t_state;

    typedef struct packed {
        logic [2:0]             kind;
        logic [2:0]             err;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
        logic [LENGTH_BITS-1:0] len;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic [QLVL_BITS-1:0] level;
        logic                 not_empty;
        logic                 has_room;
    } t_queue_status;

    localparam t_state STATE_RESET = '{
        mode:     M_IDLE,
        cur_line: LINE_BITS'(1),
        cur_col:  COLUMN_BITS'(1),
        tok_line: LINE_BITS'(1),
        tok_col:  COLUMN_BITS'(1),
        run_len:  '0
    };

endpackage
`default_nettype wire

[rtl/sxt_lexer.sv]
// next-state and result logic for one text byte of the tokenizer
// depends on sxt_pkg; purely combinational
`default_nettype none
module sxt_lexer (
    input  var sxt_pkg::t_state  i_state,
    input  var logic [7:0]       i_byte,
    output var sxt_pkg::t_state  o_next,
    output var sxt_pkg::t_result o_res0,
    output var sxt_pkg::t_result o_res1,
    output var logic [1:0]       o_count
);
    import sxt_pkg::*;

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

    typedef struct packed {
        t_state  st;
        logic    emit;
        t_result res;
    } t_idle;

    function automatic logic is_space(logic [7:0] b);
        return b inside {CH_SPACE, CH_TAB, CH_NEWLINE, CH_VTAB, CH_FFEED, CH_CR};
    endfunction

    function automatic logic is_term(logic [7:0] b);
        return (b == CH_END) || is_space(b) || (b == CH_OPAREN) || (b == CH_CPAREN);
    endfunction

    function automatic t_state advance(t_state s, logic [7:0] b);
        t_state r;
        r = s;
        if (b == CH_NEWLINE) begin
            if (s.cur_line != LINE_MAX) r.cur_line = s.cur_line + 1'b1;
            r.cur_col = COLUMN_BITS'(1);
        end else if (s.cur_col != COL_MAX) begin
            r.cur_col = s.cur_col + 1'b1;
        end
        return r;
    endfunction

    function automatic t_state grow(t_state s);
        t_state r;
        r = s;
        if (s.run_len != LEN_MAX) r.run_len = s.run_len + 1'b1;
        return r;
    endfunction

    function automatic t_state begin_token(t_state s, t_mode m);
        t_state r;
        r = s;
        r.mode     = m;
        r.tok_line = s.cur_line;
        r.tok_col  = s.cur_col;
        r.run_len  = LENGTH_BITS'(1);
        return r;
    endfunction

    function automatic t_result mk_res(logic [2:0] kind, logic [2:0] err,
                                       logic [LINE_BITS-1:0] line,
                                       logic [COLUMN_BITS-1:0] col,
                                       logic [LENGTH_BITS-1:0] len);
        t_result r;
        r.kind = kind;
        r.err  = err;
        r.line = line;
        r.col  = col;
        r.len  = len;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic t_idle idle_byte(t_state s, logic [7:0] b);
        t_idle r;
        t_state s0;
        s0     = s;
        s0.mode = M_IDLE;
        r.st   = s0;
        r.emit = 1'b0;
        r.res  = mk_res(KIND_END, ERR_NONE, s0.cur_line, s0.cur_col, '0);
        if (b == CH_END) begin
            r.emit = 1'b1;
            r.st   = STATE_RESET;
        end else if (b == CH_OPAREN || b == CH_CPAREN || b == CH_QUOTE) begin
            r.emit = 1'b1;
            r.res.kind = (b == CH_OPAREN) ? KIND_OPAREN :
                         (b == CH_CPAREN) ? KIND_CPAREN : KIND_QUOTE;
            r.res.len  = LENGTH_BITS'(1);
            r.st = advance(s0, b);
        end else if (is_space(b)) begin
            r.st = advance(s0, b);
        end else if (b == CH_DQUOTE) begin
            r.st = advance(begin_token(s0, M_STRING), b);
        end else if (b == CH_COLON) begin
            r.st = advance(begin_token(s0, M_SYMBOL), b);
        end else if (b == CH_SEMI) begin
            s0.mode = M_COMMENT;
            r.st = advance(s0, b);
        end else begin
            r.st = advance(begin_token(s0, M_ATOM), b);
        end
        return r;
    endfunction

    t_idle   w_idle;
    t_state  w_grown;
    t_result w_tok;
    logic [2:0] w_sym_err;

    always_comb begin
        w_idle    = idle_byte(i_state, i_byte);
        w_grown   = advance(grow(i_state), i_byte);
        w_tok     = mk_res(KIND_ATOM, ERR_NONE, i_state.tok_line, i_state.tok_col,
                           i_state.run_len);
        w_sym_err = (i_byte == CH_END)     ? ERR_SYMBOL_END :
                    (i_byte == CH_NEWLINE) ? ERR_LINE_END :
                    is_space(i_byte)       ? ERR_SYMBOL_SPACE : ERR_SYMBOL_PAREN;

        o_next  = w_idle.st;
        o_res0  = w_idle.res;
        o_res1  = w_idle.res;
        o_count = {1'b0, w_idle.emit};

        case (i_state.mode)
            M_STRING: begin
                o_res0 = w_tok;
                o_res0.kind = KIND_STRING;
                if (i_byte == CH_END || i_byte == CH_NEWLINE) begin
                    o_res0.err = (i_byte == CH_END) ? ERR_STRING_END : ERR_LINE_END;
                    o_next  = STATE_RESET;
                    o_count = 2'd1;
                end else begin
                    o_next  = w_grown;
                    o_res0.len = w_grown.run_len;
                    o_count = 2'd0;
                    if (i_byte == CH_DQUOTE) begin
                        o_next.mode = M_IDLE;
                        o_count = 2'd1;
                    end
                end
            end
            M_SYMBOL, M_ATOM: begin
                o_res0 = w_tok;
                o_res0.kind = (i_state.mode == M_SYMBOL) ? KIND_SYMBOL : KIND_ATOM;
                if (!is_term(i_byte)) begin
                    o_next  = w_grown;
                    o_count = 2'd0;
                end else if (i_state.mode == M_SYMBOL &&
                             i_state.run_len == LENGTH_BITS'(1)) begin
                    o_res0.err = w_sym_err;
                    o_next  = STATE_RESET;
                    o_count = 2'd1;
                end else begin
                    o_next  = w_idle.st;
                    o_count = w_idle.emit ? 2'd2 : 2'd1;
                end
            end
            M_COMMENT: begin
                if (i_byte != CH_END && i_byte != CH_NEWLINE) begin
                    o_next  = advance(i_state, i_byte);
                    o_count = 2'd0;
                end
            end
            default: begin
            end
        endcase

        o_res0.last = (o_count == 2'd1);
        o_res1.last = 1'b1;
    end

endmodule
`default_nettype wire

[rtl/sxt_queue.sv]
// four-entry result queue that takes up to two results per cycle
// depends on sxt_pkg
`default_nettype none
module sxt_queue (
    input  var logic                   i_clk,
    input  var logic                   i_rst_n,
    input  var logic [1:0]             i_push_count,
    input  var sxt_pkg::t_result       i_res0,
    input  var sxt_pkg::t_result       i_res1,
    input  var logic                   i_pop,
    output var sxt_pkg::t_result       o_head,
    output var sxt_pkg::t_queue_status o_status
);
    import sxt_pkg::*;

    t_result              r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr, n_wr;
    logic [QPTR_BITS-1:0] r_rd, n_rd;
    logic [QLVL_BITS-1:0] r_level, n_level;
    logic [QPTR_BITS-1:0] w_wr1;
    logic                 w_pop;

    always_comb begin
        w_pop   = i_pop && (r_level != '0);
        w_wr1   = r_wr + 1'b1;
        n_wr    = r_wr + QPTR_BITS'(i_push_count);
        n_rd    = w_pop ? r_rd + 1'b1 : r_rd;
        n_level = r_level + QLVL_BITS'(i_push_count) - QLVL_BITS'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) r_mem[r_wr] <= i_res0;
        if (i_push_count == 2'd2) r_mem[w_wr1] <= i_res1;
    end

    assign o_head             = r_mem[r_rd];
    assign o_status.level     = r_level;
    assign o_status.not_empty = (r_level != '0);
    assign o_status.has_room  = (r_level <= QLVL_BITS'(QUEUE_DEPTH - 2));

endmodule
`default_nettype wire

[rtl/s_expression_tokenizer.sv]
// s-expression tokenizer: one text byte in, zero to two token results out
// usage: the text channel (i_text_valid / o_text_ready) carries one byte per transaction,
// byte 0 marking end of input. the token channel (o_token_valid / i_token_ready) carries
// one token per transaction: kind, error code, start line and column, length, and a flag
// on the last token caused by a given byte.
// each accepted byte updates the scanner state in the same cycle, so a byte is taken
// every cycle while the queue has room. its tokens are written into a four-entry
// output queue as the byte is accepted; a byte that closes an atom or symbol and is
// itself a token gives two tokens, which leave one per cycle while the receiver is ready.
// the text channel is ready while the queue has room for two tokens, so bytes keep
// flowing while the receiver takes one token per cycle; a stalled receiver fills the
// queue and then holds off the text channel until tokens are taken.
// reset empties the queue and puts the scanner between tokens at line 1, column 1;
// an end-of-input byte or an error returns the scanner to that position.
// depends on sxt_pkg, sxt_lexer and sxt_queue
`default_nettype none
module s_expression_tokenizer (
    input  var logic                            i_clk,
    input  var logic                            i_rst_n,
    input  var logic                            i_text_valid,
    output var logic                            o_text_ready,
    input  var logic [7:0]                      i_text_byte,
    output var logic                            o_token_valid,
    input  var logic                            i_token_ready,
    output var logic [2:0]                      o_token_kind,
    output var logic [2:0]                      o_error_code,
    output var logic [sxt_pkg::LINE_BITS-1:0]   o_start_line,
    output var logic [sxt_pkg::COLUMN_BITS-1:0] o_start_column,
    output var logic [sxt_pkg::LENGTH_BITS-1:0] o_token_length,
    output var logic                            o_last_of_run
);
    import sxt_pkg::*;

    t_state        r_state, n_state;
    t_result       w_res0, w_res1, w_head;
    logic [1:0]    w_count, w_push;
    logic          w_accept;
    t_queue_status w_qstat;

    sxt_lexer u_lexer (
        .i_state (r_state),
        .i_byte  (i_text_byte),
        .o_next  (n_state),
        .o_res0  (w_res0),
        .o_res1  (w_res1),
        .o_count (w_count)
    );

    assign w_accept = i_text_valid && o_text_ready;
    assign w_push   = w_accept ? w_count : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    sxt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (w_push),
        .i_res0       (w_res0),
        .i_res1       (w_res1),
        .i_pop        (i_token_ready),
        .o_head       (w_head),
        .o_status     (w_qstat)
    );

    assign o_text_ready   = w_qstat.has_room;
    assign o_token_valid  = w_qstat.not_empty;
    assign o_token_kind   = w_head.kind;
    assign o_error_code   = w_head.err;
    assign o_start_line   = w_head.line;
    assign o_start_column = w_head.col;
    assign o_token_length = w_head.len;
    assign o_last_of_run  = w_head.last;

`ifndef NO_ASSERTIONS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.level <= QLVL_BITS'(QUEUE_DEPTH))
        else $error("result queue level beyond depth");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_text_byte == CH_END) |=>
        (r_state.mode == M_IDLE && r_state.cur_line == LINE_BITS'(1) &&
         r_state.cur_col == COLUMN_BITS'(1)))
        else $error("end of input did not return scanner to reset position");

    a_token_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == M_STRING || r_state.mode == M_SYMBOL ||
         r_state.mode == M_ATOM) |-> (r_state.run_len != '0))
        else $error("open token with zero length");

    a_no_push_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_accept && !i_token_ready) |=> $stable(w_qstat.level))
        else $error("queue level moved without a transaction");
`endif

endmodule
`default_nettype wire

[dv/tb_s_expression_tokenizer.sv]
// testbench for s_expression_tokenizer: drives text bytes, predicts every token and checks
// each one field by field against the oldest prediction
// depends on sxt_pkg and s_expression_tokenizer
`default_nettype none
module tb_s_expression_tokenizer;
    import sxt_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_BYTES = 500;
    localparam int PRINT_LIMIT = 100;
    localparam logic [LINE_BITS-1:0]   LINE_TOP = '1;
    localparam logic [COLUMN_BITS-1:0] COL_TOP  = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_TOP  = '1;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_STRING, SCAN_SYMBOL, SCAN_ATOM, SCAN_COMMENT
    } scan_e;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_text_valid = 1'b0;
    logic [7:0] i_text_byte = 8'h00;
    logic i_token_ready = 1'b0;
    logic o_text_ready;
    logic o_token_valid;
    logic [2:0] o_token_kind;
    logic [2:0] o_error_code;
    logic [LINE_BITS-1:0] o_start_line;
    logic [COLUMN_BITS-1:0] o_start_column;
    logic [LENGTH_BITS-1:0] o_token_length;
    logic o_last_of_run;

    s_expression_tokenizer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_text_valid   (i_text_valid),
        .o_text_ready   (o_text_ready),
        .i_text_byte    (i_text_byte),
        .o_token_valid  (o_token_valid),
        .i_token_ready  (i_token_ready),
        .o_token_kind   (o_token_kind),
        .o_error_code   (o_error_code),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    logic [7:0] pending_text[$];
    t_result expected_tokens[$];
    int bytes_queued = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    bit pressure_on = 1'b0;
    int hold_count = 0;
    logic byte_taken = 1'b0;

    // tokenizer state as predicted
    scan_e scan;
    logic [LINE_BITS-1:0] pos_line, tok_line;
    logic [COLUMN_BITS-1:0] pos_col, tok_col;
    logic [LENGTH_BITS-1:0] tok_len;
    t_result held_token;
    bit held_valid;

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_NEWLINE || b == CH_VTAB ||
               b == CH_FFEED || b == CH_CR;
    endfunction

    function automatic bit ends_word(input logic [7:0] b);
        return b == CH_END || is_blank(b) || b == CH_OPAREN || b == CH_CPAREN;
    endfunction

    task automatic clear_scanner();
        scan = SCAN_IDLE;
        pos_line = LINE_BITS'(1);
        pos_col = COLUMN_BITS'(1);
        tok_line = LINE_BITS'(1);
        tok_col = COLUMN_BITS'(1);
        tok_len = '0;
    endtask

    task automatic move_position(input logic [7:0] b);
        if (b == CH_NEWLINE) begin
            if (pos_line != LINE_TOP) pos_line = pos_line + 1'b1;
            pos_col = COLUMN_BITS'(1);
        end else if (pos_col != COL_TOP) begin
            pos_col = pos_col + 1'b1;
        end
    endtask

    task automatic lengthen();
        if (tok_len != LEN_TOP) tok_len = tok_len + 1'b1;
    endtask

    // the newest token of a byte is held back so that it can carry the last flag
    task automatic add_token(input logic [2:0] kind, input logic [2:0] err,
                             input logic [LINE_BITS-1:0] line,
                             input logic [COLUMN_BITS-1:0] col,
                             input logic [LENGTH_BITS-1:0] len);
        if (held_valid) expected_tokens.push_back(held_token);
        held_token.kind = kind;
        held_token.err = err;
        held_token.line = line;
        held_token.col = col;
        held_token.len = len;
        held_token.last = 1'b0;
        held_valid = 1'b1;
    endtask

    task automatic abort_token(input logic [2:0] kind, input logic [2:0] err);
        add_token(kind, err, tok_line, tok_col, tok_len);
        clear_scanner();
    endtask

    task automatic open_token(input scan_e mode);
        scan = mode;
        tok_line = pos_line;
        tok_col = pos_col;
        tok_len = LENGTH_BITS'(1);
    endtask

    task automatic lex_between(input logic [7:0] b);
        if (b == CH_END) begin
            add_token(KIND_END, ERR_NONE, pos_line, pos_col, '0);
            clear_scanner();
        end else begin
            if (b == CH_OPAREN || b == CH_CPAREN || b == CH_QUOTE)
                add_token((b == CH_OPAREN) ? KIND_OPAREN :
                          (b == CH_CPAREN) ? KIND_CPAREN : KIND_QUOTE,
                          ERR_NONE, pos_line, pos_col, LENGTH_BITS'(1));
            else if (b == CH_DQUOTE)
                open_token(SCAN_STRING);
            else if (b == CH_COLON)
                open_token(SCAN_SYMBOL);
            else if (b == CH_SEMI)
                scan = SCAN_COMMENT;
            else if (!is_blank(b))
                open_token(SCAN_ATOM);
            move_position(b);
        end
    endtask

    task automatic lex_byte(input logic [7:0] b);
        held_valid = 1'b0;
        case (scan)
            SCAN_STRING: begin
                if (b == CH_END) begin
                    abort_token(KIND_STRING, ERR_STRING_END);
                end else if (b == CH_NEWLINE) begin
                    abort_token(KIND_STRING, ERR_LINE_END);
                end else begin
                    lengthen();
                    move_position(b);
                    if (b == CH_DQUOTE) begin
                        add_token(KIND_STRING, ERR_NONE, tok_line, tok_col, tok_len);
                        scan = SCAN_IDLE;
                    end
                end
            end
            SCAN_SYMBOL, SCAN_ATOM: begin
                if (!ends_word(b)) begin
                    lengthen();
                    move_position(b);
                end else if (scan == SCAN_SYMBOL && tok_len == LENGTH_BITS'(1)) begin
                    abort_token(KIND_SYMBOL,
                                (b == CH_END) ? ERR_SYMBOL_END :
                                (b == CH_NEWLINE) ? ERR_LINE_END :
                                is_blank(b) ? ERR_SYMBOL_SPACE : ERR_SYMBOL_PAREN);
                end else begin
                    add_token((scan == SCAN_SYMBOL) ? KIND_SYMBOL : KIND_ATOM, ERR_NONE,
                              tok_line, tok_col, tok_len);
                    scan = SCAN_IDLE;
                    lex_between(b);
                end
            end
            SCAN_COMMENT: begin
                if (b == CH_END || b == CH_NEWLINE) begin
                    scan = SCAN_IDLE;
                    lex_between(b);
                end else begin
                    move_position(b);
                end
            end
            default: lex_between(b);
        endcase
        if (held_valid) begin
            held_token.last = 1'b1;
            expected_tokens.push_back(held_token);
        end
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input longint got, input longint want);
        if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic check_token();
        t_result want;
        if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("token of kind %0d with none expected", o_token_kind));
        end else begin
            want = expected_tokens.pop_front();
            compare_field("token_kind", o_token_kind, want.kind);
            compare_field("error_code", o_error_code, want.err);
            compare_field("start_line", o_start_line, want.line);
            compare_field("start_column", o_start_column, want.col);
            compare_field("token_length", o_token_length, want.len);
            compare_field("last_of_run", o_last_of_run, want.last);
        end
    endtask

    // monitor: text transactions feed the prediction, token transactions are checked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_taken <= 1'b0;
            clear_scanner();
        end else begin
            byte_taken <= i_text_valid && o_text_ready;
            if (i_text_valid && o_text_ready) lex_byte(i_text_byte);
            if (o_token_valid && i_token_ready) check_token();
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (pressure_on && hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_text_valid <= 1'b0;
            i_text_byte <= 8'h00;
        end else if (!i_text_valid || byte_taken) begin
            if (pending_text.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                i_text_valid <= 1'b1;
                i_text_byte <= pending_text.pop_front();
            end else begin
                i_text_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_token_ready <= 1'b0;
        else
            i_token_ready <= !(pressure_on && hold_count < HOLD_CYCLES) &&
                             $urandom_range(99) >= receiver_idle_pct;
    end

    task automatic put(input logic [7:0] b);
        pending_text.push_back(b);
        bytes_queued++;
    endtask

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_NEWLINE;
            3: return CH_VTAB;
            4: return CH_FFEED;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255, 1)); while (ends_word(b));
        return b;
    endfunction

    function automatic logic [7:0] string_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255, 1)); while (b == CH_DQUOTE || b == CH_NEWLINE);
        return b;
    endfunction

    function automatic logic [7:0] comment_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255, 1)); while (b == CH_NEWLINE);
        return b;
    endfunction

    // mostly well-formed tokens with random content, plus noise and broken tokens
    task automatic push_random_text(input int count);
        int goal;
        int pick;
        goal = bytes_queued + count;
        while (bytes_queued < goal) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                repeat ($urandom_range(4, 1)) put(8'($urandom_range(255)));
            end else if (pick < 20) begin
                case ($urandom_range(2))
                    0: put(CH_OPAREN);
                    1: put(CH_CPAREN);
                    default: put(CH_QUOTE);
                endcase
            end else if (pick < 33) begin
                repeat ($urandom_range(3, 1)) put(blank_byte());
            end else if (pick < 50) begin
                repeat ($urandom_range(8, 1)) put(word_byte());
                case ($urandom_range(3))
                    0: put(blank_byte());
                    1: put(CH_OPAREN);
                    2: put(CH_CPAREN);
                    default: ;
                endcase
            end else if (pick < 60) begin
                put(CH_COLON);
                repeat ($urandom_range(6, 1)) put(word_byte());
            end else if (pick < 72) begin
                put(CH_DQUOTE);
                repeat ($urandom_range(8)) put(string_byte());
                put(CH_DQUOTE);
            end else if (pick < 80) begin
                put(CH_SEMI);
                repeat ($urandom_range(8)) put(comment_byte());
                put(CH_NEWLINE);
            end else if (pick < 86) begin
                put(CH_DQUOTE);
                repeat ($urandom_range(4)) put(string_byte());
                put($urandom_range(1) ? CH_END : CH_NEWLINE);
            end else if (pick < 93) begin
                put(CH_COLON);
                case ($urandom_range(4))
                    0: put(CH_END);
                    1: put(CH_NEWLINE);
                    2: put(blank_byte());
                    3: put(CH_OPAREN);
                    default: put(CH_CPAREN);
                endcase
            end else begin
                put(CH_END);
            end
        end
    endtask

    task automatic wait_settled();
        do @(posedge i_clk);
        while (pending_text.size() != 0 || i_text_valid || expected_tokens.size() != 0);
    endtask

    logic [7:0] directed_text[27];

    initial begin
        directed_text = '{CH_OPAREN, CH_CPAREN, CH_QUOTE, CH_DQUOTE, CH_DQUOTE,
                          CH_COLON, 8'h6B, CH_OPAREN, CH_SEMI, CH_NEWLINE, CH_VTAB,
                          CH_COLON, CH_SPACE, CH_COLON, CH_NEWLINE, CH_COLON, CH_CPAREN,
                          CH_DQUOTE, CH_END, CH_DQUOTE, CH_NEWLINE, 8'hFF, CH_END,
                          CH_COLON, CH_END, CH_SEMI, CH_END};
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        foreach (directed_text[i]) put(directed_text[i]);
        wait_settled();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
                1: begin sender_idle_pct = 73; receiver_idle_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_idle_pct = 73; end
                default: begin sender_idle_pct = 38; receiver_idle_pct = 38; end
            endcase
            push_random_text(RANDOM_BYTES);
            wait_settled();
        end

        // receiver held off while atoms closed by parens keep arriving
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        pressure_on = 1'b1;
        repeat (60) begin
            put(word_byte());
            put(CH_CPAREN);
        end
        wait_settled();
        pressure_on = 1'b0;

        repeat (20) @(posedge i_clk);
        if (expected_tokens.size() != 0)
            report_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
